>>> rtl/bcg_pkg.sv
// ============================================================================
// bcg_pkg - battery charge gauge shared definitions
// Field widths, scaling constants, control word layout and the microcode
// program that steps the gauge datapath through one item.
// ============================================================================
package bcg_pkg;

    // Field widths
    localparam int VOLT_W     = 16;
    localparam int CUR_W      = 16;
    localparam int CV_W       = 13;
    localparam int CAP_W      = 15;
    localparam int CUT_W      = 12;
    localparam int STATUS_W   = 2;
    localparam int SOC_W      = 7;
    localparam int LEVEL_W    = 27;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 2;

    // Configuration reset values
    localparam logic [CV_W-1:0]  CV_RST  = CV_W'(4200);
    localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(5200);
    localparam logic [CUT_W-1:0] CUT_RST = CUT_W'(3500);

    localparam int FULL_DEBOUNCE_LIMIT_DEF = 5;

    // Scaling constants
    localparam int K_VFULL_PCT  = 95;
    localparam int K_IFULL_PCT  = 2;
    localparam int K_FULL_PCT   = 70;
    localparam int K_SEC_PER_H  = 3600;
    localparam int K_TOP_OFFSET = 125;
    localparam int K_PERCENT    = 100;

    // Multiplier: 27 x 23 bits, product registered
    localparam int MUL_A_W = LEVEL_W;
    localparam int MUL_B_W = 23;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // x/100 as (x * ceil(2^29/100)) >> 29, exact for x below about six million
    localparam int                 REC_SHIFT = 29;
    localparam logic [MUL_B_W-1:0] REC100    = MUL_B_W'(5368710);

    // Threshold widths: cv*95/100 < cv, cap*2/100 < cap/32
    localparam int VFULL_W = CV_W;
    localparam int IFULL_W = CAP_W - 5;

    // Serial divider: quotient only needed up to the percent range
    localparam int DIV_QW = SOC_W;
    localparam int DIV_VW = LEVEL_W;
    localparam int DIV_DW = LEVEL_W + SOC_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHARGE_V = 2'd0,
        CFG_CAPACITY = 2'd1,
        CFG_CUTOFF   = 2'd2
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_CHARGING    = 2'd0,
        ST_DISCHARGING = 2'd1,
        ST_FULL        = 2'd2,
        ST_EMPTY       = 2'd3
    } t_status;

    typedef struct packed {
        logic [CV_W-1:0]  cv;
        logic [CAP_W-1:0] cap;
        logic [CUT_W-1:0] cut;
    } t_cfg;

    typedef struct packed {
        t_status            status;
        logic [SOC_W-1:0]   soc;
        logic [LEVEL_W-1:0] level;
    } t_result;

    typedef struct packed {
        logic              busy;
        logic              ovf;
        logic [DIV_QW-1:0] quot;
    } t_div_res;

    typedef struct packed {
        logic in_valid;
        logic soc_fixed;
        logic div_busy;
        logic out_free;
    } t_seq_stat;

    // Program steps
    typedef enum logic [3:0] {
        S_IDLE,
        S_VF_MUL,
        S_VF_DIV,
        S_IF_MUL,
        S_IF_DIV,
        S_FC_MUL,
        S_FC_DIV,
        S_FC_SCALE,
        S_EVAL,
        S_SOC_SEL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SOC_LD,
        S_OUT
    } t_step;

    // Multiplier operand selects
    typedef enum logic [2:0] {
        MA_CV,
        MA_CAP,
        MA_P,
        MA_PQ,
        MA_SOC
    } t_mul_a;

    typedef enum logic [2:0] {
        MB_95,
        MB_2,
        MB_70,
        MB_REC,
        MB_3600,
        MB_100
    } t_mul_b;

    // Sequencing of the step counter
    typedef enum logic [2:0] {
        J_NEXT,
        J_WAIT_IN,
        J_SOC_FIXED,
        J_DIV_BUSY,
        J_OUT_FREE
    } t_jmp;

    typedef struct packed {
        logic   accept;
        logic   mul_en;
        t_mul_a mul_a;
        t_mul_b mul_b;
        logic   ld_vfull;
        logic   ld_ifull;
        logic   eval;
        logic   soc_sel;
        logic   div_start;
        logic   soc_ld;
        logic   out_wr;
        t_jmp   jmp;
        t_step  target;
    } t_ctrl;

    // Microcode ROM: one control word per step
    function automatic t_ctrl ucode(input t_step s);
        t_ctrl w;
        w = '0;
        unique case (s)
            S_IDLE: begin
                w.accept = 1'b1;
                w.jmp    = J_WAIT_IN;
            end
            S_VF_MUL: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_CV;
                w.mul_b  = MB_95;
            end
            S_VF_DIV: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_P;
                w.mul_b  = MB_REC;
            end
            S_IF_MUL: begin
                w.ld_vfull = 1'b1;
                w.mul_en   = 1'b1;
                w.mul_a    = MA_CAP;
                w.mul_b    = MB_2;
            end
            S_IF_DIV: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_P;
                w.mul_b  = MB_REC;
            end
            S_FC_MUL: begin
                w.ld_ifull = 1'b1;
                w.mul_en   = 1'b1;
                w.mul_a    = MA_CAP;
                w.mul_b    = MB_70;
            end
            S_FC_DIV: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_P;
                w.mul_b  = MB_REC;
            end
            S_FC_SCALE: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_PQ;
                w.mul_b  = MB_3600;
            end
            S_EVAL: begin
                w.eval = 1'b1;
            end
            S_SOC_SEL: begin
                w.soc_sel = 1'b1;
                w.mul_en  = 1'b1;
                w.mul_a   = MA_SOC;
                w.mul_b   = MB_100;
                w.jmp     = J_SOC_FIXED;
                w.target  = S_OUT;
            end
            S_DIV_GO: begin
                w.div_start = 1'b1;
            end
            S_DIV_WAIT: begin
                w.jmp = J_DIV_BUSY;
            end
            S_SOC_LD: begin
                w.soc_ld = 1'b1;
            end
            S_OUT: begin
                w.out_wr = 1'b1;
                w.jmp    = J_OUT_FREE;
                w.target = S_IDLE;
            end
            default: begin
                // unused step codes fall back to idle
                w.jmp    = J_OUT_FREE;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/bcg_seq.sv
// ============================================================================
// bcg_seq - microcode sequencer
// Step counter with conditional jumps; the current step addresses the
// control word ROM that drives the datapath.
// ============================================================================
module bcg_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bcg_pkg::t_seq_stat i_stat,
    output bcg_pkg::t_ctrl     o_ctrl
);
    import bcg_pkg::*;

    t_step r_step;
    t_step n_step;
    t_step w_inc;
    t_ctrl w_ctrl;

    assign w_inc = t_step'(r_step + 1'b1);

    // next step
    always_comb begin
        unique case (w_ctrl.jmp)
            J_NEXT:      n_step = w_inc;
            J_WAIT_IN:   n_step = i_stat.in_valid ? w_inc : r_step;
            J_SOC_FIXED: n_step = i_stat.soc_fixed ? w_ctrl.target : w_inc;
            J_DIV_BUSY:  n_step = i_stat.div_busy ? r_step : w_inc;
            J_OUT_FREE:  n_step = i_stat.out_free ? w_ctrl.target : r_step;
            default:     n_step = S_IDLE;
        endcase
    end

    // control word out of the ROM
    always_comb begin
        w_ctrl = ucode(r_step);
        o_ctrl = w_ctrl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // the program only returns to idle from the result step
    a_idle_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_step == S_IDLE && $past(r_step) != S_IDLE)
            |-> $past(r_step) == S_OUT)
        else $error("sequencer entered idle from an unexpected step");

endmodule

>>> rtl/bcg_div.sv
// ============================================================================
// bcg_div - serial percent divider
// Restoring division, one quotient bit per cycle. Quotients of 128 and
// more are flagged as overflow at start.
// ============================================================================
module bcg_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [bcg_pkg::DIV_DW-1:0]   i_dividend,
    input  logic [bcg_pkg::DIV_VW-1:0]   i_divisor,
    output bcg_pkg::t_div_res            o_res
);
    import bcg_pkg::*;

    localparam int CNT_W = $clog2(DIV_QW);

    logic              r_busy;
    logic              r_ovf;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_sd;
    logic [DIV_QW-1:0] r_quot;
    logic              w_fit;

    assign w_fit = (r_rem >= r_sd);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_QW - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // remainder, shifted divisor and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf  <= (i_dividend >= {i_divisor, {DIV_QW{1'b0}}});
            r_rem  <= i_dividend;
            r_sd   <= DIV_DW'({i_divisor, {(DIV_QW - 1){1'b0}}});
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - r_sd;
            end
            r_quot <= {r_quot[DIV_QW-2:0], w_fit};
            r_sd   <= r_sd >> 1;
        end
    end

    assign o_res = '{busy: r_busy, ovf: r_ovf, quot: r_quot};

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while still busy");

endmodule

>>> rtl/bcg_dp.sv
// ============================================================================
// bcg_dp - gauge datapath
// Shared multiplier, threshold and charge registers, status decision and
// state-of-charge selection, all stepped by the microcode control word.
// ============================================================================
module bcg_dp #(
    parameter int FULL_DEBOUNCE_LIMIT = bcg_pkg::FULL_DEBOUNCE_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bcg_pkg::t_ctrl                    i_ctrl,
    input  logic                              i_accept,
    input  logic [bcg_pkg::VOLT_W-1:0]        i_voltage_mv,
    input  logic signed [bcg_pkg::CUR_W-1:0]  i_current_ma,
    input  bcg_pkg::t_cfg                     i_cfg,
    input  bcg_pkg::t_div_res                 i_div,
    output logic                              o_soc_fixed,
    output logic [bcg_pkg::DIV_DW-1:0]        o_dividend,
    output logic [bcg_pkg::DIV_VW-1:0]        o_divisor,
    output bcg_pkg::t_result                  o_result
);
    import bcg_pkg::*;

    localparam int              DB_W     = $clog2(FULL_DEBOUNCE_LIMIT + 2);
    localparam logic [DB_W-1:0] DB_LIMIT = DB_W'(FULL_DEBOUNCE_LIMIT);
    localparam logic [SOC_W-1:0] SOC_MAX = SOC_W'(K_PERCENT);

    // item and working registers
    logic [VOLT_W-1:0]        r_volt;
    logic signed [CUR_W-1:0]  r_cur;
    logic [PROD_W-1:0]        r_prod;
    logic [VFULL_W-1:0]       r_vfull;
    logic [IFULL_W-1:0]       r_ifull;
    logic [SOC_W-1:0]         r_soc;
    logic [LEVEL_W-1:0]       r_divisor;

    // gauge state
    logic [DB_W-1:0]          r_db;
    logic [LEVEL_W-1:0]       r_counter;
    logic [LEVEL_W-1:0]       r_fcv;
    logic                     r_est;
    t_status                  r_status;

    logic [MUL_A_W-1:0]       w_mul_a;
    logic [MUL_B_W-1:0]       w_mul_b;
    logic [PROD_W-1:0]        w_prod;
    logic signed [CUR_W:0]    w_cur_ext;
    logic [CUR_W:0]           w_abs_cur;
    logic                     w_full_cond;
    logic                     w_full_now;
    logic [DB_W-1:0]          n_db;
    logic                     w_cur_pos;
    logic [LEVEL_W-1:0]       w_dis_amt;
    logic [LEVEL_W:0]         w_chg_sum;
    t_status                  w_status_new;
    logic [LEVEL_W-1:0]       w_counter_new;
    logic signed [CV_W:0]     w_top;
    logic signed [VOLT_W:0]   w_volt_s;
    logic                     w_above_top;
    logic signed [CV_W+1:0]   w_span;
    logic [VOLT_W-1:0]        w_vdiff;
    logic                     w_soc_fixed;
    logic [SOC_W-1:0]         w_soc_fix_val;
    logic [SOC_W-1:0]         w_soc_div;

    // multiplier operand selection
    always_comb begin
        unique case (i_ctrl.mul_a)
            MA_CV:   w_mul_a = MUL_A_W'(i_cfg.cv);
            MA_CAP:  w_mul_a = MUL_A_W'(i_cfg.cap);
            MA_P:    w_mul_a = r_prod[MUL_A_W-1:0];
            MA_PQ:   w_mul_a = MUL_A_W'(r_prod[PROD_W-1:REC_SHIFT]);
            MA_SOC:  w_mul_a = r_est ? MUL_A_W'(w_vdiff) : r_counter;
            default: w_mul_a = '0;
        endcase
        unique case (i_ctrl.mul_b)
            MB_95:   w_mul_b = MUL_B_W'(K_VFULL_PCT);
            MB_2:    w_mul_b = MUL_B_W'(K_IFULL_PCT);
            MB_70:   w_mul_b = MUL_B_W'(K_FULL_PCT);
            MB_REC:  w_mul_b = REC100;
            MB_3600: w_mul_b = MUL_B_W'(K_SEC_PER_H);
            MB_100:  w_mul_b = MUL_B_W'(K_PERCENT);
            default: w_mul_b = '0;
        endcase
    end

    assign w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // full-charge detection and debounce
    assign w_cur_ext = {r_cur[CUR_W-1], r_cur};
    assign w_abs_cur = r_cur[CUR_W-1] ? (CUR_W + 1)'(-w_cur_ext) : (CUR_W + 1)'(w_cur_ext);

    always_comb begin
        w_full_cond = (r_volt > VOLT_W'(r_vfull)) && (w_abs_cur < (CUR_W + 1)'(r_ifull));
        w_full_now  = w_full_cond && (r_db > DB_LIMIT);
        if (!w_full_cond) begin
            n_db = '0;
        end else if (r_db > DB_LIMIT) begin
            n_db = r_db;
        end else begin
            n_db = r_db + 1'b1;
        end
    end

    // status and charge counter update
    assign w_cur_pos = !r_cur[CUR_W-1] && (r_cur != '0);
    assign w_dis_amt = LEVEL_W'(r_cur[CUR_W-2:0]);
    assign w_chg_sum = (LEVEL_W + 1)'(r_counter) + (LEVEL_W + 1)'(w_abs_cur);

    always_comb begin
        priority if (w_full_now) begin
            w_status_new  = ST_FULL;
            w_counter_new = r_prod[LEVEL_W-1:0];
        end else if (r_volt < VOLT_W'(i_cfg.cut)) begin
            w_status_new  = ST_EMPTY;
            w_counter_new = '0;
        end else if (w_cur_pos) begin
            w_status_new  = ST_DISCHARGING;
            w_counter_new = (r_counter < w_dis_amt) ? '0 : r_counter - w_dis_amt;
        end else begin
            w_status_new  = ST_CHARGING;
            w_counter_new = (w_chg_sum > (LEVEL_W + 1)'(r_fcv)) ? r_fcv
                                                                : w_chg_sum[LEVEL_W-1:0];
        end
    end

    // voltage line: top of line is charge voltage less the offset, signed
    assign w_top       = $signed({1'b0, i_cfg.cv}) - $signed((CV_W + 1)'(K_TOP_OFFSET));
    assign w_volt_s    = $signed({1'b0, r_volt});
    assign w_above_top = w_volt_s > $signed((VOLT_W + 1)'(w_top));
    // span and offset are only used once the voltage sits between cutoff and top
    assign w_span      = $signed({w_top[CV_W], w_top}) - $signed((CV_W + 2)'(i_cfg.cut));
    assign w_vdiff     = r_volt - VOLT_W'(i_cfg.cut);

    // state of charge settled without a divide
    always_comb begin
        w_soc_fixed   = 1'b1;
        w_soc_fix_val = '0;
        priority if (r_status == ST_FULL) begin
            w_soc_fix_val = SOC_MAX;
        end else if (r_status == ST_EMPTY) begin
            w_soc_fix_val = '0;
        end else if (r_est) begin
            w_soc_fixed   = w_above_top;
            w_soc_fix_val = SOC_MAX;
        end else if (r_counter > r_fcv) begin
            w_soc_fix_val = SOC_MAX;
        end else if (r_fcv == '0) begin
            w_soc_fix_val = '0;
        end else begin
            w_soc_fixed = 1'b0;
        end
    end

    assign w_soc_div = (i_div.ovf || i_div.quot > SOC_MAX) ? SOC_MAX : i_div.quot;

    // item, product and working registers
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_volt <= i_voltage_mv;
            r_cur  <= i_current_ma;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_ctrl.ld_vfull) begin
            r_vfull <= r_prod[REC_SHIFT +: VFULL_W];
        end
        if (i_ctrl.ld_ifull) begin
            r_ifull <= r_prod[REC_SHIFT +: IFULL_W];
        end
        if (i_ctrl.soc_sel) begin
            r_divisor <= r_est ? LEVEL_W'(w_span[CV_W-1:0]) : r_fcv;
            if (w_soc_fixed) begin
                r_soc <= w_soc_fix_val;
            end
        end
        if (i_ctrl.soc_ld) begin
            r_soc <= w_soc_div;
        end
    end

    // gauge state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_db      <= '0;
            r_counter <= '0;
            r_fcv     <= '0;
            r_est     <= 1'b1;
            r_status  <= ST_CHARGING;
        end else if (i_ctrl.eval) begin
            r_db      <= n_db;
            r_counter <= w_counter_new;
            r_status  <= w_status_new;
            if (w_full_now) begin
                r_fcv <= r_prod[LEVEL_W-1:0];
                r_est <= 1'b0;
            end
        end
    end

    assign o_soc_fixed = w_soc_fixed;
    assign o_dividend  = r_prod[DIV_DW-1:0];
    assign o_divisor   = r_divisor;
    assign o_result    = '{status: r_status, soc: r_soc, level: r_counter};

    a_counter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_counter <= r_fcv)
        else $error("charge counter above full-charge value");

    a_full_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status == ST_FULL) |-> (r_counter == r_fcv))
        else $error("full status without counter at full-charge value");

endmodule

>>> rtl/battery_charge_gauge.sv
// ============================================================================
// battery_charge_gauge - coulomb counting fuel gauge
// Classifies each voltage/current item, keeps the charge counter and reports
// the state of charge, run by a microcoded sequencer over one datapath.
//
//   Channel  Direction  Handshake                 Fields
//   in       to block   i_in_valid / o_in_stall   i_voltage_mv, i_current_ma
//   out      from block o_out_valid / i_out_stall o_battery_status,
//                                                 o_state_of_charge,
//                                                 o_charge_level
//   cfg      to block   i_cfg_we                  i_cfg_index, i_cfg_data
//
// Each item runs through the multiplier steps for the constant scalings;
// when the state of charge is not settled by a limit, it then needs the
// divide, done by the serial divider at one quotient bit a cycle.
// Items are taken only in the idle step; a finished result waits in the
// output register while the next item is worked on, and a second result
// holds the sequencer until the first is taken. Reset is synchronous and
// needs no clearing pass; configuration returns to its defaults.
// ============================================================================
module battery_charge_gauge #(
    parameter int FULL_DEBOUNCE_LIMIT = bcg_pkg::FULL_DEBOUNCE_LIMIT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [bcg_pkg::VOLT_W-1:0]          i_voltage_mv,
    input  logic signed [bcg_pkg::CUR_W-1:0]    i_current_ma,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [bcg_pkg::STATUS_W-1:0]        o_battery_status,
    output logic [bcg_pkg::SOC_W-1:0]           o_state_of_charge,
    output logic [bcg_pkg::LEVEL_W-1:0]         o_charge_level,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [bcg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bcg_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bcg_pkg::*;

    t_cfg              r_cfg;
    logic              r_out_valid;
    t_result           r_out;

    t_ctrl             w_ctrl;
    t_seq_stat         w_stat;
    t_div_res          w_div;
    t_result           w_result;
    logic              w_accept;
    logic              w_out_free;
    logic              w_out_wr;
    logic              w_soc_fixed;
    logic [DIV_DW-1:0] w_dividend;
    logic [DIV_VW-1:0] w_divisor;

    // handshakes
    assign o_in_stall = !w_ctrl.accept;
    assign w_accept   = w_ctrl.accept && i_in_valid;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_out_wr   = w_ctrl.out_wr && w_out_free;

    assign w_stat = '{in_valid:  i_in_valid,
                      soc_fixed: w_soc_fixed,
                      div_busy:  w_div.busy,
                      out_free:  w_out_free};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{cv: CV_RST, cap: CAP_RST, cut: CUT_RST};
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CHARGE_V: r_cfg.cv  <= i_cfg_data[CV_W-1:0];
                CFG_CAPACITY: r_cfg.cap <= i_cfg_data[CAP_W-1:0];
                CFG_CUTOFF:   r_cfg.cut <= i_cfg_data[CUT_W-1:0];
                default: begin
                    // no register at this index
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_wr) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_wr) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_battery_status  = r_out.status;
    assign o_state_of_charge = r_out.soc;
    assign o_charge_level    = r_out.level;

    bcg_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    bcg_dp #(
        .FULL_DEBOUNCE_LIMIT (FULL_DEBOUNCE_LIMIT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_accept     (w_accept),
        .i_voltage_mv (i_voltage_mv),
        .i_current_ma (i_current_ma),
        .i_cfg        (r_cfg),
        .i_div        (w_div),
        .o_soc_fixed  (w_soc_fixed),
        .o_dividend   (w_dividend),
        .o_divisor    (w_divisor),
        .o_result     (w_result)
    );

    bcg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_ctrl.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_res      (w_div)
    );

    a_soc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_state_of_charge <= SOC_W'(K_PERCENT)))
        else $error("state of charge above full scale");

    a_full_soc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_battery_status == ST_FULL)
            |-> (o_state_of_charge == SOC_W'(K_PERCENT)))
        else $error("fully charged item without full state of charge");

endmodule

>>> test/battery_charge_gauge_tb.sv
// ============================================================================
// battery_charge_gauge_tb - self-checking bench for the charge gauge
// Walks a short table of hand-picked samples, then runs several register
// settings with random runs of samples (full-charge runs, drains, charges,
// cut-off hits, threshold edges and noise). Each result item is checked against
// its table row or a behavioural model kept in step with each accepted sample.
// ============================================================================
module battery_charge_gauge_tb;
    import bcg_pkg::*;

    localparam int DEBOUNCE_LIMIT = FULL_DEBOUNCE_LIMIT_DEF;
    localparam int SETTLE_CYCLES  = 30;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 175;
    localparam int N_PHASES       = 8;
    localparam int MAX_PRINTS     = 40;

    typedef enum int {
        RUN_FULL,
        RUN_DRAIN,
        RUN_CHARGE,
        RUN_EMPTY,
        RUN_EDGE,
        RUN_NOISE
    } t_run;

    typedef struct {
        logic [VOLT_W-1:0]        volt;
        logic signed [CUR_W-1:0]  cur;
        bit                       has_exp;
        t_result                  res;
    } t_dir_row;

    // DUT signals
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [VOLT_W-1:0]           i_voltage_mv = '0;
    logic signed [CUR_W-1:0]     i_current_ma = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [STATUS_W-1:0]         o_battery_status;
    logic [SOC_W-1:0]            o_state_of_charge;
    logic [LEVEL_W-1:0]          o_charge_level;
    logic                        i_cfg_we = 1'b0;
    t_cfg_idx                    i_cfg_index = CFG_CHARGE_V;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;

    // Gauge model state and its copy of the registers
    int      cfg_cv  = int'(CV_RST);
    int      cfg_cap = int'(CAP_RST);
    int      cfg_cut = int'(CUT_RST);
    int      debounce_count = 0;
    longint  gauge_level = 0;
    longint  gauge_full = 0;
    bit      by_voltage = 1'b1;

    t_result  pending_results[$];
    t_dir_row dir_tab[$];

    int n_errors  = 0;
    int n_sent    = 0;
    int n_checked = 0;
    int n_cfg     = 0;
    int n_status [4] = '{0, 0, 0, 0};
    int burst_left = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    int stall_mode = 0;

    int phase_cv  [5] = '{4500, 3800, 3800, 4500, 4200};
    int phase_cap [5] = '{32767, 100, 32767, 100, 5200};
    int phase_cut [5] = '{2500, 3600, 3600, 2500, 3500};

    battery_charge_gauge #(
        .FULL_DEBOUNCE_LIMIT(DEBOUNCE_LIMIT)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_voltage_mv      (i_voltage_mv),
        .i_current_ma      (i_current_ma),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_battery_status  (o_battery_status),
        .o_state_of_charge (o_state_of_charge),
        .o_charge_level    (o_charge_level),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // Clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int rand_span(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Gauge model: classify one sample, update the counter, work out the percentage
    function automatic t_result gauge_predict(input logic [VOLT_W-1:0] v,
                                              input logic signed [CUR_W-1:0] c);
        longint  volt, cur, mag, vfull, ifull, cut, top, q;
        bit      full_now;
        t_result r;
        volt = v;
        cur = c;
        mag = (cur < 0) ? -cur : cur;
        vfull = longint'(cfg_cv) * 95 / 100;
        ifull = longint'(cfg_cap) * 2 / 100;
        cut = cfg_cut;
        full_now = 1'b0;

        // debounce saturates one above the limit
        if (volt > vfull && mag < ifull) begin
            if (debounce_count > DEBOUNCE_LIMIT)
                full_now = 1'b1;
            else
                debounce_count++;
        end else begin
            debounce_count = 0;
        end

        if (full_now) begin
            r.status = ST_FULL;
            gauge_full = (longint'(cfg_cap) * 70 / 100) * 3600;
            gauge_level = gauge_full;
            by_voltage = 1'b0;
        end else if (volt < cut) begin
            r.status = ST_EMPTY;
            gauge_level = 0;
        end else if (cur > 0) begin
            r.status = ST_DISCHARGING;
            gauge_level = gauge_level - cur;
            if (gauge_level < 0)
                gauge_level = 0;
        end else begin
            // before the first full charge the ceiling is zero
            r.status = ST_CHARGING;
            gauge_level = gauge_level - cur;
            if (gauge_level > gauge_full)
                gauge_level = gauge_full;
        end

        if (r.status == ST_FULL) begin
            q = 100;
        end else if (r.status == ST_EMPTY) begin
            q = 0;
        end else if (by_voltage) begin
            top = longint'(cfg_cv) - 125;
            if (volt > top)
                q = 100;
            else if (volt < cut)
                q = 0;
            else if (top == cut)
                q = 100;
            else
                q = (volt - cut) * 100 / (top - cut);
        end else begin
            if (gauge_level > gauge_full)
                q = 100;
            else if (gauge_full == 0)
                q = 0;
            else
                q = gauge_level * 100 / gauge_full;
        end
        if (q > 100)
            q = 100;

        r.soc = SOC_W'(q);
        r.level = LEVEL_W'(gauge_level);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        if (n_errors < MAX_PRINTS)
            $display("tb: mismatch on result %0d, %s: expected %0d, got %0d",
                     n_checked, what, want, got);
        n_errors++;
    endtask

    task automatic add_row(input int v, input int c, input bit has_exp,
                           input t_status st, input int soc, input int lvl);
        t_dir_row row;
        row.volt = VOLT_W'(v);
        row.cur = CUR_W'(c);
        row.has_exp = has_exp;
        row.res.status = st;
        row.res.soc = SOC_W'(soc);
        row.res.level = LEVEL_W'(lvl);
        dir_tab.push_back(row);
    endtask

    // Present one sample, hold it until taken, then log what it should produce
    task automatic send_sample(input logic [VOLT_W-1:0] volt,
                               input logic signed [CUR_W-1:0] cur,
                               input bit has_exp, input t_result fixed_res);
        t_result res;
        int      gap;
        i_in_valid <= 1'b1;
        i_voltage_mv <= volt;
        i_current_ma <= cur;
        do @(posedge i_clk); while (o_in_stall);
        res = gauge_predict(volt, cur);
        pending_results.push_back(has_exp ? fixed_res : res);
        n_sent++;

        // bursts of random length, random gaps between them
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Stop sending and wait for every pending result, then let the block settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(input int cv, input int cap, input int cut);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_CHARGE_V;
        i_cfg_data <= CFG_DATA_W'(cv);
        @(posedge i_clk);
        i_cfg_index <= CFG_CAPACITY;
        i_cfg_data <= CFG_DATA_W'(cap);
        @(posedge i_clk);
        i_cfg_index <= CFG_CUTOFF;
        i_cfg_data <= CFG_DATA_W'(cut);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_cv = cv;
        cfg_cap = cap;
        cfg_cut = cut;
        n_cfg++;
    endtask

    // Receiver stall: modes of free flow, light, heavy and long blocks
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 200);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 1) == 0);
            default: i_out_stall <= ((stall_left % 32) < 20);
        endcase
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_status[o_battery_status]++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item, status", -1, o_battery_status);
            end else begin
                want = pending_results.pop_front();
                if (o_battery_status !== want.status)
                    report_mismatch("battery_status", want.status, o_battery_status);
                if (o_state_of_charge !== want.soc)
                    report_mismatch("state_of_charge", want.soc, o_state_of_charge);
                if (o_charge_level !== want.level)
                    report_mismatch("charge_level", want.level, o_charge_level);
            end
            n_checked++;
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: watchdog expired with %0d results pending", pending_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus
    initial begin : stimulus
        t_run run_kind;
        int   run_len, volt, cur, vf, ifl, top, phase_start;

        // Directed samples at reset settings: threshold 3990, current limit 104,
        // voltage line 3500..4075, full value 13104000
        add_row(0, 0, 1'b1, ST_EMPTY, 0, 0);
        add_row(65535, 32767, 1'b1, ST_DISCHARGING, 100, 0);
        add_row(65535, -32768, 1'b1, ST_CHARGING, 100, 0);
        add_row(3500, 0, 1'b1, ST_CHARGING, 0, 0);
        add_row(4075, 1, 1'b1, ST_DISCHARGING, 100, 0);
        add_row(3787, 5, 1'b0, ST_CHARGING, 0, 0);
        add_row(3499, -5, 1'b1, ST_EMPTY, 0, 0);
        // start of a full run, broken on the voltage edge and the current edge
        add_row(4100, 0, 1'b1, ST_CHARGING, 100, 0);
        add_row(4100, 103, 1'b0, ST_CHARGING, 0, 0);
        add_row(4100, -103, 1'b0, ST_CHARGING, 0, 0);
        add_row(3990, 0, 1'b0, ST_CHARGING, 0, 0);
        add_row(4100, 104, 1'b0, ST_CHARGING, 0, 0);
        // six qualifying samples, the seventh declares full
        add_row(4100, 0, 1'b1, ST_CHARGING, 100, 0);
        add_row(4100, -103, 1'b0, ST_CHARGING, 0, 0);
        add_row(65535, 0, 1'b1, ST_CHARGING, 100, 0);
        add_row(3991, 103, 1'b0, ST_CHARGING, 0, 0);
        add_row(4100, 0, 1'b1, ST_CHARGING, 100, 0);
        add_row(4100, -1, 1'b0, ST_CHARGING, 0, 0);
        add_row(4100, 0, 1'b1, ST_FULL, 100, 13104000);
        add_row(4200, 0, 1'b1, ST_FULL, 100, 13104000);
        // counter based percentage from here on
        add_row(3800, 32767, 1'b0, ST_CHARGING, 0, 0);
        add_row(3700, -32768, 1'b1, ST_CHARGING, 100, 13104000);
        add_row(2000, 0, 1'b1, ST_EMPTY, 0, 0);
        add_row(3600, -1000, 1'b0, ST_CHARGING, 0, 0);
        add_row(3600, 5000, 1'b1, ST_DISCHARGING, 0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i])
            send_sample(dir_tab[i].volt, dir_tab[i].cur, dir_tab[i].has_exp, dir_tab[i].res);
        drain_results();

        // Random phases, each under its own register setting
        for (int p = 0; p < N_PHASES; p++) begin
            if (p < 5)
                load_config(phase_cv[p], phase_cap[p], phase_cut[p]);
            else
                load_config(rand_span(3800, 4500), rand_span(100, 32767),
                            rand_span(2500, 3600));
            vf = cfg_cv * 95 / 100;
            ifl = cfg_cap * 2 / 100;
            top = cfg_cv - 125;
            phase_start = n_sent;

            while (n_sent - phase_start < PHASE_ITEMS) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: run_kind = RUN_FULL;
                    3, 4, 9: run_kind = RUN_DRAIN;
                    5:       run_kind = RUN_CHARGE;
                    6:       run_kind = RUN_EMPTY;
                    7:       run_kind = RUN_EDGE;
                    default: run_kind = RUN_NOISE;
                endcase
                case (run_kind)
                    RUN_FULL:   run_len = $urandom_range(6, 14);
                    RUN_DRAIN:  run_len = $urandom_range(5, 40);
                    RUN_CHARGE: run_len = $urandom_range(5, 30);
                    RUN_EMPTY:  run_len = $urandom_range(1, 3);
                    RUN_EDGE:   run_len = $urandom_range(1, 4);
                    default:    run_len = $urandom_range(1, 5);
                endcase

                for (int k = 0; k < run_len; k++) begin
                    case (run_kind)
                        RUN_FULL: begin
                            // an occasional sample on the threshold breaks the run
                            if ($urandom_range(0, 19) == 0)
                                volt = vf;
                            else
                                volt = rand_span(vf + 1, cfg_cv + 300);
                            cur = rand_span(1 - ifl, ifl - 1);
                        end
                        RUN_DRAIN: begin
                            volt = rand_span(cfg_cut, cfg_cv + 200);
                            cur = ($urandom_range(0, 1) == 0) ? rand_span(1, 200)
                                                              : rand_span(1, 32767);
                        end
                        RUN_CHARGE: begin
                            volt = rand_span(cfg_cut, cfg_cv + 200);
                            cur = -rand_span(0, 32768);
                        end
                        RUN_EMPTY: begin
                            volt = rand_span(0, cfg_cut - 1);
                            cur = rand_span(-32768, 32767);
                        end
                        RUN_EDGE: begin
                            case ($urandom_range(0, 5))
                                0:       volt = vf;
                                1:       volt = vf + 1;
                                2:       volt = top;
                                3:       volt = top + 1;
                                4:       volt = cfg_cut - 1;
                                default: volt = cfg_cut;
                            endcase
                            case ($urandom_range(0, 6))
                                0:       cur = ifl - 1;
                                1:       cur = ifl;
                                2:       cur = 1 - ifl;
                                3:       cur = -ifl;
                                4:       cur = 0;
                                5:       cur = 32767;
                                default: cur = -32768;
                            endcase
                        end
                        default: begin
                            volt = $urandom_range(0, 65535);
                            cur = rand_span(-32768, 32767);
                        end
                    endcase
                    send_sample(VOLT_W'(volt), CUR_W'(cur), 1'b0, '0);
                end
            end
            drain_results();
        end

        $display("tb: %0d samples sent under %0d register settings, %0d results checked",
                 n_sent, n_cfg + 1, n_checked);
        $display("tb: results seen: %0d charging, %0d discharging, %0d full, %0d empty",
                 n_status[ST_CHARGING], n_status[ST_DISCHARGING], n_status[ST_FULL],
                 n_status[ST_EMPTY]);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
